// ----- design/sra_pkg.sv -----
package sra_pkg;

	localparam int INSTR_W = 16;
	localparam int IDX_W   = 3;
	localparam int IMM_W   = 7;
	localparam int OPC_LSB = 13;
	localparam int DST_LSB = 10;
	localparam int SRC_LSB = 7;

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_LDI  = 3'd4,
		OP_EMIT = 3'd5
	} opcode_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_req_t;

endpackage

// ----- design/sra_instr_if.sv -----
interface sra_instr_if;
	logic                         valid;
	logic                         ready;
	logic [sra_pkg::INSTR_W-1:0]  instruction;

	modport source (output valid, output instruction, input ready);
	modport sink (input valid, input instruction, output ready);
endinterface

// ----- design/sra_result_if.sv -----
interface sra_result_if #(
	parameter int DATA_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [sra_pkg::IDX_W-1:0]     reg_number;
	logic signed [DATA_WIDTH-1:0]  reg_value;

	modport source (output valid, output reg_number, output reg_value, input ready);
	modport sink (input valid, input reg_number, input reg_value, output ready);
endinterface

// ----- design/sra_ram.sv -----
module sra_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 6
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/sra_mdu.sv -----
// Shift-add multiply and restoring divide, one bit per cycle.
module sra_mdu #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sra_pkg::mdu_req_t      req,
	input  logic [DATA_WIDTH-1:0]  opa,
	input  logic [DATA_WIDTH-1:0]  opb,
	output logic                   done,
	output logic [DATA_WIDTH-1:0]  result
);

	localparam int CW = $clog2(DATA_WIDTH);

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_MUL  = 4'b0010,
		M_DIV  = 4'b0100,
		M_FIN  = 4'b1000
	} mstate_t;

	mstate_t               st_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic                  neg_q;

	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;

	assign mag_a = opa[DATA_WIDTH-1] ? (~opa + 1'b1) : opa;
	assign mag_b = opb[DATA_WIDTH-1] ? (~opb + 1'b1) : opb;
	assign trial = {rem_q, a_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					if (req.start) begin
						if (!req.is_div) begin
							st_q <= M_MUL;
						end else if (opb == '0) begin
							done_q <= 1'b1;
						end else begin
							st_q <= M_DIV;
						end
					end
				end
				M_MUL, M_DIV: begin
					if (cnt_q == '0) begin
						st_q <= M_FIN;
					end
				end
				M_FIN: begin
					st_q   <= M_IDLE;
					done_q <= 1'b1;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			M_IDLE: begin
				cnt_q <= CW'(DATA_WIDTH - 1);
				acc_q <= '0;
				rem_q <= '0;
				if (req.is_div) begin
					a_q   <= mag_a;
					b_q   <= mag_b;
					neg_q <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
					res_q <= '1;
				end else begin
					a_q   <= opa;
					b_q   <= opb;
					neg_q <= 1'b0;
				end
			end
			M_MUL: begin
				if (b_q[0]) begin
					acc_q <= acc_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			M_DIV: begin
				if (!diff[DATA_WIDTH]) begin
					rem_q <= diff[DATA_WIDTH-1:0];
				end else begin
					rem_q <= trial[DATA_WIDTH-1:0];
				end
				acc_q <= {acc_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
				a_q   <= a_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			M_FIN: begin
				res_q <= neg_q ? (~acc_q + 1'b1) : acc_q;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

// ----- design/six_register_alu_interpreter_core.sv -----
// channel    | modport | payload                  | transfer
// instr_ch   | sink    | instruction[15:0]        | valid & ready
// result_ch  | source  | reg_number, reg_value    | valid & ready
//
// Add, subtract, load, emit and the spare opcodes finish in EXEC; multiply and
// divide go on to the bit-serial mdu, which answers a divide by zero without iterating.
// Register file: two RAMs with registered reads, read at accept, written at completion.
// Reset clears per-entry valid bits so every register reads zero.
// A pending result stalls only a following emit, nothing else.
module six_register_alu_interpreter_core #(
	parameter int NUM_REGS   = 6,
	parameter int DATA_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	sra_instr_if.sink        instr_ch,
	sra_result_if.source     result_ch
);

	localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [sra_pkg::IDX_W:0] NREGS_C = (sra_pkg::IDX_W + 1)'(NUM_REGS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_MDU  = 3'b100
	} state_t;

	state_t                      st_q;
	state_t                      st_d;
	sra_pkg::opcode_t            op_q;
	logic [sra_pkg::IDX_W-1:0]   dst_q;
	logic [sra_pkg::IDX_W-1:0]   src_q;
	logic [sra_pkg::IMM_W-1:0]   imm_q;
	logic [NUM_REGS-1:0]         vld_q;

	logic                        out_valid_q;
	logic [sra_pkg::IDX_W-1:0]   out_num_q;
	logic [DATA_WIDTH-1:0]       out_val_q;

	logic                        accept;
	logic [sra_pkg::IDX_W-1:0]   in_dst;
	logic [sra_pkg::IDX_W-1:0]   in_src;
	logic [DATA_WIDTH-1:0]       rd_d;
	logic [DATA_WIDTH-1:0]       rd_s;
	logic                        dst_in_range;
	logic                        src_in_range;
	logic [DATA_WIDTH-1:0]       d_op;
	logic [DATA_WIDTH-1:0]       s_op;
	logic [DATA_WIDTH-1:0]       alu_res;
	logic                        alu_wr;
	logic                        emit_go;
	logic                        out_free;
	logic                        wr_en;
	logic [DATA_WIDTH-1:0]       wr_data;
	sra_pkg::mdu_req_t           mdu_req;
	logic                        mdu_done;
	logic [DATA_WIDTH-1:0]       mdu_res;

	assign instr_ch.ready = (st_q == S_IDLE);
	assign accept         = instr_ch.valid && instr_ch.ready;
	assign in_dst = instr_ch.instruction[sra_pkg::DST_LSB +: sra_pkg::IDX_W];
	assign in_src = instr_ch.instruction[sra_pkg::SRC_LSB +: sra_pkg::IDX_W];

	sra_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_ram_d (
		.clk   (clk),
		.we    (wr_en),
		.waddr (dst_q[AW-1:0]),
		.wdata (wr_data),
		.re    (accept),
		.raddr (in_dst[AW-1:0]),
		.rdata (rd_d)
	);

	sra_ram #(.WIDTH(DATA_WIDTH), .DEPTH(NUM_REGS)) u_ram_s (
		.clk   (clk),
		.we    (wr_en),
		.waddr (dst_q[AW-1:0]),
		.wdata (wr_data),
		.re    (accept),
		.raddr (in_src[AW-1:0]),
		.rdata (rd_s)
	);

	assign dst_in_range = {1'b0, dst_q} < NREGS_C;
	assign src_in_range = {1'b0, src_q} < NREGS_C;
	assign d_op = (dst_in_range && vld_q[dst_q[AW-1:0]]) ? rd_d : '0;
	assign s_op = (src_in_range && vld_q[src_q[AW-1:0]]) ? rd_s : '0;

	always_comb begin
		alu_res = '0;
		alu_wr  = 1'b0;
		unique case (op_q)
			sra_pkg::OP_ADD: begin
				alu_res = d_op + s_op;
				alu_wr  = 1'b1;
			end
			sra_pkg::OP_SUB: begin
				alu_res = d_op - s_op;
				alu_wr  = 1'b1;
			end
			sra_pkg::OP_LDI: begin
				alu_res = {{(DATA_WIDTH - sra_pkg::IMM_W){1'b0}}, imm_q};
				alu_wr  = 1'b1;
			end
			default: begin
				alu_wr = 1'b0;
			end
		endcase
	end

	assign out_free = !out_valid_q || result_ch.ready;
	assign emit_go  = (st_q == S_EXEC) && (op_q == sra_pkg::OP_EMIT) && dst_in_range && out_free;

	assign mdu_req.start  = (st_q == S_EXEC) &&
		((op_q == sra_pkg::OP_MUL) || (op_q == sra_pkg::OP_DIV));
	assign mdu_req.is_div = (op_q == sra_pkg::OP_DIV);

	sra_mdu #(.DATA_WIDTH(DATA_WIDTH)) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mdu_req),
		.opa    (d_op),
		.opb    (s_op),
		.done   (mdu_done),
		.result (mdu_res)
	);

	assign wr_en = (((st_q == S_EXEC) && alu_wr) || ((st_q == S_MDU) && mdu_done)) &&
		(dst_q != '0) && dst_in_range;
	assign wr_data = (st_q == S_MDU) ? mdu_res : alu_res;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_IDLE: begin
				if (accept) begin
					st_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (mdu_req.start) begin
					st_d = S_MDU;
				end else if ((op_q != sra_pkg::OP_EMIT) || !dst_in_range || out_free) begin
					st_d = S_IDLE;
				end
			end
			S_MDU: begin
				if (mdu_done) begin
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (wr_en) begin
				vld_q[dst_q[AW-1:0]] <= 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= sra_pkg::opcode_t'(instr_ch.instruction[sra_pkg::OPC_LSB +: 3]);
			dst_q <= in_dst;
			src_q <= in_src;
			imm_q <= instr_ch.instruction[sra_pkg::IMM_W-1:0];
		end
		if (emit_go) begin
			out_num_q <= dst_q;
			out_val_q <= d_op;
		end
	end

	assign result_ch.valid      = out_valid_q;
	assign result_ch.reg_number = out_num_q;
	assign result_ch.reg_value  = out_val_q;

endmodule

// ----- design/sra_chk.sv -----
module sra_chk #(
	parameter int NUM_REGS   = 6,
	parameter int DATA_WIDTH = 32
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [sra_pkg::IDX_W-1:0]        out_num,
	input logic signed [DATA_WIDTH-1:0]     out_value
);

	localparam logic [sra_pkg::IDX_W:0] NREGS_C = (sra_pkg::IDX_W + 1)'(NUM_REGS);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_num) && $stable(out_value))
		else $error("result transaction changed while stalled");

	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, out_num} < NREGS_C))
		else $error("emitted register index beyond the file");

	a_zero_reg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_num == '0) |-> (out_value == '0))
		else $error("register zero emitted non-zero");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("instruction taken while previous one still executing");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind six_register_alu_interpreter_core sra_chk #(
	.NUM_REGS   (NUM_REGS),
	.DATA_WIDTH (DATA_WIDTH)
) u_sra_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (instr_ch.valid),
	.in_ready  (instr_ch.ready),
	.out_valid (result_ch.valid),
	.out_ready (result_ch.ready),
	.out_num   (result_ch.reg_number),
	.out_value (result_ch.reg_value)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

	localparam int NUM_REGS    = 6;
	localparam int DATA_W      = 32;
	localparam int RESET_CYC   = 8;
	localparam int RANDOM_N    = 1800;
	localparam int BURST_N     = 48;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYC    = 60;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 10;

	localparam logic [2:0] OPC_SPARE_A = 3'd6;
	localparam logic [2:0] OPC_SPARE_B = 3'd7;

	localparam logic [2:0] R0 = 3'd0;
	localparam logic [2:0] R1 = 3'd1;
	localparam logic [2:0] R2 = 3'd2;
	localparam logic [2:0] R3 = 3'd3;
	localparam logic [2:0] R4 = 3'd4;
	localparam logic [2:0] R5 = 3'd5;
	localparam logic [2:0] R6 = 3'd6;
	localparam logic [2:0] R7 = 3'd7;

	typedef struct {
		logic                         pause;
		logic [sra_pkg::INSTR_W-1:0]  instr;
	} backlog_entry_t;

	typedef struct {
		logic [sra_pkg::IDX_W-1:0]    number;
		logic signed [DATA_W-1:0] value;
	} emit_t;

	logic clk;
	logic arst_n;

	sra_instr_if                      instr_ch();
	sra_result_if #(.DATA_WIDTH(DATA_W)) result_ch();

	six_register_alu_interpreter_core #(
		.NUM_REGS  (NUM_REGS),
		.DATA_WIDTH(DATA_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.instr_ch (instr_ch),
		.result_ch(result_ch)
	);

	backlog_entry_t           instr_backlog[$];
	emit_t                    emits_expected[$];
	logic signed [DATA_W-1:0] shadow_regs[NUM_REGS];

	logic        instr_taken;
	logic        drain_wait;
	logic        long_hold_done;
	int          send_gap;
	int          recv_gap;
	int          hold_left;
	int          hold_at;
	int          cycle_cnt;
	int          items_accepted;
	int          results_checked;
	int          mismatches;
	int          div_by_zero;
	int          op_seen[8];
	logic        nxt_valid;
	logic [15:0] nxt_instr;
	logic        nxt_ready;
	backlog_entry_t nxt_entry;

	always #5 clk = ~clk;

	function automatic logic [sra_pkg::INSTR_W-1:0] make_instr(logic [2:0] op, logic [2:0] dst,
			logic [2:0] src, logic [sra_pkg::IMM_W-1:0] imm);
		logic [sra_pkg::INSTR_W-1:0] w;
		w = '0;
		w[sra_pkg::OPC_LSB +: 3]   = op;
		w[sra_pkg::DST_LSB +: 3]   = dst;
		w[sra_pkg::SRC_LSB +: 3]   = src;
		w[sra_pkg::IMM_W-1:0]      = imm;
		return w;
	endfunction

	function automatic logic signed [DATA_W-1:0] read_reg(logic [2:0] idx);
		if (idx < NUM_REGS)
			return shadow_regs[idx];
		return '0;
	endfunction

	function automatic int pick_gap();
		int r;
		if (((cycle_cnt / 2000) % 5) == 4)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_instr(logic [2:0] op, logic [2:0] dst, logic [2:0] src,
			logic [sra_pkg::IMM_W-1:0] imm);
		backlog_entry_t e;
		e.pause = 1'b0;
		e.instr = make_instr(op, dst, src, imm);
		instr_backlog.push_back(e);
	endtask

	task automatic queue_pause();
		backlog_entry_t e;
		e.pause = 1'b1;
		e.instr = '0;
		instr_backlog.push_back(e);
	endtask

	task automatic execute_instr(logic [sra_pkg::INSTR_W-1:0] ins);
		logic [2:0]               op, dst, src;
		logic signed [DATA_W-1:0] d, s, r;
		longint                   q;
		emit_t                    em;
		logic                     wr;
		op  = ins[sra_pkg::OPC_LSB +: 3];
		dst = ins[sra_pkg::DST_LSB +: 3];
		src = ins[sra_pkg::SRC_LSB +: 3];
		d   = read_reg(dst);
		s   = read_reg(src);
		r   = '0;
		wr  = 1'b1;
		op_seen[op]++;
		case (op)
			sra_pkg::OP_ADD: r = d + s;
			sra_pkg::OP_SUB: r = d - s;
			sra_pkg::OP_MUL: r = d * s;
			sra_pkg::OP_DIV: begin
				if (s == 0) begin
					r = '1;
					div_by_zero++;
				end else begin
					q = longint'(d) / longint'(s);
					r = q[DATA_W-1:0];
				end
			end
			sra_pkg::OP_LDI: r = DATA_W'(ins[sra_pkg::IMM_W-1:0]);
			sra_pkg::OP_EMIT: begin
				wr = 1'b0;
				if (dst < NUM_REGS) begin
					em.number = dst;
					em.value  = d;
					emits_expected.push_back(em);
				end
			end
			default: wr = 1'b0;
		endcase
		if (wr && dst != R0 && dst < NUM_REGS)
			shadow_regs[dst] = r;
	endtask

	// source side
	always @(negedge clk) begin
		nxt_valid = instr_ch.valid;
		nxt_instr = instr_ch.instruction;
		if (arst_n) begin
			if (instr_ch.valid && instr_taken)
				nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (drain_wait) begin
					if (emits_expected.size() == 0)
						drain_wait = 1'b0;
				end else if (send_gap > 0) begin
					send_gap--;
				end else if (instr_backlog.size() > 0) begin
					nxt_entry = instr_backlog.pop_front();
					if (nxt_entry.pause) begin
						drain_wait = 1'b1;
					end else begin
						nxt_valid = 1'b1;
						nxt_instr = nxt_entry.instr;
						send_gap  = pick_gap();
					end
				end
			end
		end else begin
			nxt_valid = 1'b0;
		end
		instr_ch.valid       <= nxt_valid;
		instr_ch.instruction <= nxt_instr;
	end

	// sink side
	always @(negedge clk) begin
		nxt_ready = 1'b0;
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
			end else if (!long_hold_done && items_accepted >= hold_at) begin
				long_hold_done = 1'b1;
				hold_left      = LONG_HOLD;
			end else if (recv_gap > 0) begin
				recv_gap--;
			end else begin
				nxt_ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					recv_gap = pick_gap();
			end
		end
		result_ch.ready <= nxt_ready;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			instr_taken <= instr_ch.valid && instr_ch.ready;
			if (instr_ch.valid && instr_ch.ready) begin
				execute_instr(instr_ch.instruction);
				items_accepted++;
			end
			if (result_ch.valid && result_ch.ready) begin
				results_checked++;
				if (emits_expected.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("ERROR: unexpected transaction reg %0d value %0d",
							result_ch.reg_number, result_ch.reg_value);
					mismatches++;
				end else begin
					automatic emit_t ex = emits_expected.pop_front();
					if (ex.number !== result_ch.reg_number ||
							ex.value !== result_ch.reg_value) begin
						if (mismatches < MAX_REPORTS)
							$display("ERROR: reg exp %0d got %0d, value exp %0d got %0d",
								ex.number, result_ch.reg_number, ex.value,
								result_ch.reg_value);
						mismatches++;
					end
				end
			end
		end else begin
			instr_taken <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		automatic int    queued = 0;
		automatic int    r;
		automatic logic [2:0] op, dst, src;
		clk             = 1'b0;
		arst_n          = 1'b0;
		instr_ch.valid  = 1'b0;
		instr_ch.instruction = '0;
		result_ch.ready = 1'b0;
		instr_taken     = 1'b0;
		drain_wait      = 1'b0;
		long_hold_done  = 1'b0;
		send_gap        = 0;
		recv_gap        = 0;
		hold_left       = 0;
		cycle_cnt       = 0;
		items_accepted  = 0;
		results_checked = 0;
		mismatches      = 0;
		div_by_zero     = 0;
		foreach (op_seen[i])
			op_seen[i] = 0;
		foreach (shadow_regs[i])
			shadow_regs[i] = '0;

		// directed
		queue_instr(sra_pkg::OP_EMIT, R0, R0, 7'd0);
		queue_instr(sra_pkg::OP_LDI,  R1, R0, 7'd127);
		queue_instr(sra_pkg::OP_LDI,  R2, R7, 7'd1);
		queue_instr(sra_pkg::OP_ADD,  R1, R2, 7'd0);
		queue_instr(sra_pkg::OP_SUB,  R2, R1, 7'd0);
		queue_instr(sra_pkg::OP_MUL,  R1, R2, 7'd127);
		queue_instr(sra_pkg::OP_EMIT, R1, R0, 7'd0);
		queue_instr(sra_pkg::OP_DIV,  R1, R0, 7'd0);
		queue_instr(sra_pkg::OP_EMIT, R1, R0, 7'd0);
		queue_instr(sra_pkg::OP_LDI,  R3, R0, 7'd64);
		queue_instr(sra_pkg::OP_MUL,  R3, R3, 7'd0);
		queue_instr(sra_pkg::OP_MUL,  R3, R3, 7'd0);
		queue_instr(sra_pkg::OP_LDI,  R4, R0, 7'd64);
		queue_instr(sra_pkg::OP_MUL,  R3, R4, 7'd0);
		queue_instr(sra_pkg::OP_ADD,  R3, R3, 7'd0);
		queue_instr(sra_pkg::OP_DIV,  R3, R1, 7'd0);
		queue_instr(sra_pkg::OP_EMIT, R3, R0, 7'd0);
		queue_instr(sra_pkg::OP_LDI,  R0, R0, 7'd5);
		queue_instr(sra_pkg::OP_ADD,  R6, R1, 7'd0);
		queue_instr(sra_pkg::OP_LDI,  R7, R0, 7'd15);
		queue_instr(sra_pkg::OP_ADD,  R4, R6, 7'd0);
		queue_instr(sra_pkg::OP_SUB,  R5, R7, 7'd0);
		queue_instr(sra_pkg::OP_EMIT, R6, R0, 7'd0);
		queue_instr(sra_pkg::OP_EMIT, R7, R0, 7'd0);
		queue_instr(OPC_SPARE_A, R1, R2, 7'd127);
		queue_instr(OPC_SPARE_B, R2, R3, 7'd0);
		queue_instr(sra_pkg::OP_EMIT, R0, R0, 7'd127);
		queue_instr(sra_pkg::OP_EMIT, R4, R0, 7'd0);
		queue_instr(sra_pkg::OP_EMIT, R2, R0, 7'd0);
		queued = instr_backlog.size();
		queue_pause();

		// random
		hold_at = queued;
		for (int n = 0; n < RANDOM_N; n++) begin
			if (n == 300 || n == 1000 || n == 1500)
				queue_pause();
			if (n == 580) begin
				hold_at = queued + 5;
				for (int b = 0; b < BURST_N; b++) begin
					queue_instr(sra_pkg::OP_EMIT, 3'($urandom_range(0, 5)),
						3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
					queued++;
				end
			end
			r = $urandom_range(0, 99);
			if (r < 20)      op = sra_pkg::OP_LDI;
			else if (r < 32) op = sra_pkg::OP_ADD;
			else if (r < 44) op = sra_pkg::OP_SUB;
			else if (r < 56) op = sra_pkg::OP_MUL;
			else if (r < 68) op = sra_pkg::OP_DIV;
			else if (r < 92) op = sra_pkg::OP_EMIT;
			else             op = 3'($urandom_range(6, 7));
			r = $urandom_range(0, 15);
			dst = (r < 12) ? 3'(1 + r % 5) : (r == 12) ? R0 : (r == 13) ? R6 : R7;
			r = $urandom_range(0, 15);
			src = (r < 11) ? 3'(1 + r % 5) : (r < 13) ? R0 : (r == 13) ? R6 : R7;
			queue_instr(op, dst, src, 7'($urandom_range(0, 127)));
			queued++;
		end

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (instr_backlog.size() != 0 || instr_ch.valid || drain_wait)
			@(posedge clk);
		while (emits_expected.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		if (emits_expected.size() != 0) begin
			$display("ERROR: %0d results never arrived", emits_expected.size());
			mismatches++;
		end
		$display("%0d instructions run (add %0d sub %0d mul %0d div %0d ldi %0d spare %0d)",
			items_accepted, op_seen[sra_pkg::OP_ADD], op_seen[sra_pkg::OP_SUB],
			op_seen[sra_pkg::OP_MUL], op_seen[sra_pkg::OP_DIV], op_seen[sra_pkg::OP_LDI],
			op_seen[OPC_SPARE_A] + op_seen[OPC_SPARE_B]);
		$display("%0d emits checked, %0d divides by zero, %0d mismatches",
			results_checked, div_by_zero, mismatches);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
